// ===== rtl/tef_pkg.sv =====
// Shared constants, payload structs and stage records for the truss tangent pipeline.
package tef_pkg;

  localparam int COORD_WIDTH = 32;
  localparam int FRAC_BITS   = 16;
  localparam int VAL_W       = 32;                 // stiffness and force width
  localparam int OUT_W       = 48;                 // result entry width
  localparam int DIFF_W      = COORD_WIDTH + 1;    // node difference
  localparam int SQ_W        = 2 * DIFF_W;         // one squared component
  localparam int REM_W       = SQ_W + 2;           // sum of three squares
  localparam int ROOT_W      = DIFF_W;             // bar length, sqrt(3) * 2^(DIFF_W-1) fits
  localparam int MAG_W       = (DIFF_W > VAL_W) ? DIFF_W : VAL_W;
  localparam int NUM_W       = MAG_W + FRAC_BITS;  // dividend and quotient width
  localparam int LANES       = 4;                  // three directions plus n/L
  localparam int LANE_FORCE  = 3;
  localparam int TW          = FRAC_BITS + 2;      // signed unit component, |t| <= 1.0
  localparam int QW          = NUM_W + 1;          // signed n/L
  localparam int CW          = QW + 1;             // signed k - n/L
  localparam int PW          = CW + TW;            // c*t and ct*t products
  localparam int FPW         = VAL_W + TW;         // n*t product
  localparam int FW          = VAL_W + 2;          // node force after truncation
  localparam int SW          = CW + 1;             // block entry before clamping

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] start_x;
    logic signed [COORD_WIDTH-1:0] start_y;
    logic signed [COORD_WIDTH-1:0] start_z;
    logic signed [COORD_WIDTH-1:0] end_x;
    logic signed [COORD_WIDTH-1:0] end_y;
    logic signed [COORD_WIDTH-1:0] end_z;
    logic signed [VAL_W-1:0]       axial_stiffness;
    logic signed [VAL_W-1:0]       axial_force;
  } tef_in_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] b_xx;
    logic signed [OUT_W-1:0] b_yy;
    logic signed [OUT_W-1:0] b_zz;
    logic signed [OUT_W-1:0] b_xy;
    logic signed [OUT_W-1:0] b_xz;
    logic signed [OUT_W-1:0] b_yz;
    logic signed [OUT_W-1:0] force_x;
    logic signed [OUT_W-1:0] force_y;
    logic signed [OUT_W-1:0] force_z;
    logic                    zero_length;
    logic                    saturated;
  } tef_out_t;

  // direction split into sign and magnitude, plus k and n
  typedef struct packed {
    logic [2:0]                neg;
    logic [2:0][DIFF_W-1:0]    dmag;
    logic signed [VAL_W-1:0]   k;
    logic signed [VAL_W-1:0]   n;
  } tef_bar_t;

  typedef struct packed {
    logic                valid;
    tef_bar_t            bar;
    logic [ROOT_W-1:0]   len;
  } tef_len_res_t;

  // what rides alongside the divider lanes
  typedef struct packed {
    logic [2:0]                neg;
    logic signed [VAL_W-1:0]   k;
    logic signed [VAL_W-1:0]   n;
    logic [ROOT_W-1:0]         den;
  } tef_dctl_t;

  typedef struct packed {
    logic                         valid;
    tef_dctl_t                    ctl;
    logic [LANES-1:0][NUM_W-1:0]  quot;
  } tef_div_res_t;

  typedef struct packed {
    logic     valid;
    tef_out_t data;
  } tef_back_res_t;

endpackage

// ===== rtl/tef_len.sv =====
// Node difference, squared length and bit-per-stage square root pipeline.
module tef_len import tef_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         en,
  input  logic         in_valid,
  input  tef_in_t      req,
  output tef_len_res_t res
);

  logic signed [DIFF_W-1:0] d [3];
  tef_bar_t                 bar_next;

  logic                     va, vb;
  tef_bar_t                 bar_a, bar_b;
  logic [SQ_W-1:0]          sq [3];

  logic                     vl [ROOT_W+1];
  tef_bar_t                 br [ROOT_W+1];
  logic [ROOT_W-1:0]        rt [ROOT_W+1];
  logic [REM_W-1:0]         rm [ROOT_W];

  always_comb begin
    d[0] = DIFF_W'(req.end_x) - DIFF_W'(req.start_x);
    d[1] = DIFF_W'(req.end_y) - DIFF_W'(req.start_y);
    d[2] = DIFF_W'(req.end_z) - DIFF_W'(req.start_z);
    for (int i = 0; i < 3; i++) begin
      bar_next.neg[i]  = d[i][DIFF_W-1];
      bar_next.dmag[i] = d[i][DIFF_W-1] ? DIFF_W'(-d[i]) : DIFF_W'(d[i]);
    end
    bar_next.k = req.axial_stiffness;
    bar_next.n = req.axial_force;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      va    <= 1'b0;
      vb    <= 1'b0;
      vl[0] <= 1'b0;
    end else if (en) begin
      va    <= in_valid;
      vb    <= va;
      vl[0] <= vb;
    end
    if (en) begin
      bar_a <= bar_next;
      bar_b <= bar_a;
      br[0] <= bar_b;
      for (int i = 0; i < 3; i++) begin
        sq[i] <= SQ_W'(bar_a.dmag[i]) * SQ_W'(bar_a.dmag[i]);
      end
      rm[0] <= REM_W'(sq[0]) + REM_W'(sq[1]) + REM_W'(sq[2]);
    end
  end

  assign rt[0] = '0;

  // stage g settles root bit ROOT_W-1-g; rm holds S - root^2
  for (genvar g = 0; g < ROOT_W; g++) begin : g_root
    localparam int B = ROOT_W - 1 - g;
    logic [REM_W-1:0] inc;
    logic             take;

    assign inc  = (REM_W'(rt[g]) << (B + 1)) | (REM_W'(1) << (2 * B));
    assign take = (rm[g] >= inc);

    always_ff @(posedge clk) begin
      if (rst) begin
        vl[g+1] <= 1'b0;
      end else if (en) begin
        vl[g+1] <= vl[g];
      end
      if (en) begin
        br[g+1] <= br[g];
        rt[g+1] <= take ? (rt[g] | (ROOT_W'(1) << B)) : rt[g];
      end
    end

    if (g < ROOT_W - 1) begin : g_rem
      always_ff @(posedge clk) begin
        if (en) begin
          rm[g+1] <= take ? (rm[g] - inc) : rm[g];
        end
      end
    end
  end

  assign res.valid = vl[ROOT_W];
  assign res.bar   = br[ROOT_W];
  assign res.len   = rt[ROOT_W];

endmodule

// ===== rtl/tef_div.sv =====
// Four-lane restoring divider, one quotient bit per stage: |d_i|*2^F/L and |n|*2^F/L.
module tef_div import tef_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         en,
  input  tef_len_res_t lr,
  output tef_div_res_t res
);

  logic                         v   [NUM_W+1];
  tef_dctl_t                    ctl [NUM_W+1];
  logic [LANES-1:0][NUM_W-1:0]  nq  [NUM_W+1];
  logic [LANES-1:0][ROOT_W-1:0] pr  [NUM_W];
  logic [MAG_W-1:0]             nmag;

  assign nmag = lr.bar.n[VAL_W-1] ? MAG_W'(-lr.bar.n) : MAG_W'(lr.bar.n);

  assign v[0]       = lr.valid;
  assign ctl[0].neg = lr.bar.neg;
  assign ctl[0].k   = lr.bar.k;
  assign ctl[0].n   = lr.bar.n;
  assign ctl[0].den = lr.len;
  assign pr[0]      = '0;

  for (genvar l = 0; l < 3; l++) begin : g_dir
    assign nq[0][l] = NUM_W'(lr.bar.dmag[l]) << FRAC_BITS;
  end
  assign nq[0][LANE_FORCE] = NUM_W'(nmag) << FRAC_BITS;

  // nq: remaining dividend bits shift out the top, quotient bits shift in below
  for (genvar g = 0; g < NUM_W; g++) begin : g_stage
    logic [LANES-1:0]              ge;
    logic [LANES-1:0][ROOT_W-1:0]  prn;
    logic [LANES-1:0][NUM_W-1:0]   nqn;

    for (genvar l = 0; l < LANES; l++) begin : g_lane
      logic [ROOT_W:0] x;
      assign x      = {pr[g][l], nq[g][l][NUM_W-1]};
      assign ge[l]  = (x >= {1'b0, ctl[g].den});
      assign prn[l] = ge[l] ? ROOT_W'(x - {1'b0, ctl[g].den}) : ROOT_W'(x);
      assign nqn[l] = {nq[g][l][NUM_W-2:0], ge[l]};
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v[g+1] <= 1'b0;
      end else if (en) begin
        v[g+1] <= v[g];
      end
      if (en) begin
        ctl[g+1] <= ctl[g];
        nq[g+1]  <= nqn;
      end
    end

    if (g < NUM_W - 1) begin : g_rem
      always_ff @(posedge clk) begin
        if (en) begin
          pr[g+1] <= prn;
        end
      end
    end
  end

  assign res.valid = v[NUM_W];
  assign res.ctl   = ctl[NUM_W];
  assign res.quot  = nq[NUM_W];

endmodule

// ===== rtl/tef_back.sv =====
// Signed products, tangent block assembly, clamping and the zero-length override.
module tef_back import tef_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  tef_div_res_t  dr,
  output tef_back_res_t res
);

  localparam int PI [6] = '{0, 1, 2, 0, 0, 1};
  localparam int PJ [6] = '{0, 1, 2, 1, 2, 2};

  // stage 0: signs applied
  logic                    v0, z0;
  logic signed [QW-1:0]    q0;
  logic signed [CW-1:0]    c0;
  logic signed [TW-1:0]    t0 [3];
  logic signed [VAL_W-1:0] n0;
  // stage 1: first products
  logic                    v1, z1;
  logic signed [QW-1:0]    q1;
  logic signed [TW-1:0]    t1 [3];
  logic signed [PW-1:0]    pct1 [3];
  logic signed [FPW-1:0]   pf1 [3];
  // stage 2: truncated
  logic                    v2, z2;
  logic signed [QW-1:0]    q2;
  logic signed [TW-1:0]    t2 [3];
  logic signed [CW-1:0]    ct2 [3];
  logic signed [FW-1:0]    f2 [3];
  // stage 3: block products
  logic                    v3, z3;
  logic signed [QW-1:0]    q3;
  logic signed [FW-1:0]    f3 [3];
  logic signed [PW-1:0]    pb3 [6];
  // stage 4: result
  logic                    v4;
  tef_out_t                o4;

  logic signed [QW-1:0]    qm;
  logic signed [TW-1:0]    tm [3];
  logic signed [PW-1:0]    adj2 [3];
  logic signed [FPW-1:0]   adjf [3];
  logic signed [PW-1:0]    adjb [6];
  logic signed [SW-1:0]    ent [6];
  logic [OUT_W:0]          cl [6];
  tef_out_t                o_next;

  function automatic logic [OUT_W:0] clamp(input logic signed [SW-1:0] val);
    logic signed [SW-1:0] omax;
    logic signed [SW-1:0] omin;
    omax = SW'({1'b0, {(OUT_W-1){1'b1}}});
    omin = -omax - SW'(1);
    if (val > omax) begin
      clamp = {1'b1, OUT_W'(omax)};
    end else if (val < omin) begin
      clamp = {1'b1, OUT_W'(omin)};
    end else begin
      clamp = {1'b0, OUT_W'(val)};
    end
  endfunction

  always_comb begin
    qm = QW'(dr.quot[LANE_FORCE]);
    for (int i = 0; i < 3; i++) begin
      tm[i]   = TW'(dr.quot[i]);
      adj2[i] = pct1[i] + (pct1[i][PW-1] ? PW'((1 << FRAC_BITS) - 1) : PW'(0));
      adjf[i] = pf1[i] + (pf1[i][FPW-1] ? FPW'((1 << FRAC_BITS) - 1) : FPW'(0));
    end
    for (int e = 0; e < 6; e++) begin
      adjb[e] = pb3[e] + (pb3[e][PW-1] ? PW'((1 << FRAC_BITS) - 1) : PW'(0));
      ent[e]  = SW'(CW'(adjb[e] >>> FRAC_BITS)) + ((e < 3) ? SW'(q3) : SW'(0));
      cl[e]   = clamp(ent[e]);
    end
    o_next.b_xx        = cl[0][OUT_W-1:0];
    o_next.b_yy        = cl[1][OUT_W-1:0];
    o_next.b_zz        = cl[2][OUT_W-1:0];
    o_next.b_xy        = cl[3][OUT_W-1:0];
    o_next.b_xz        = cl[4][OUT_W-1:0];
    o_next.b_yz        = cl[5][OUT_W-1:0];
    // |n*t| is at most 2^31, never clamps
    o_next.force_x     = OUT_W'(f3[0]);
    o_next.force_y     = OUT_W'(f3[1]);
    o_next.force_z     = OUT_W'(f3[2]);
    o_next.zero_length = 1'b0;
    o_next.saturated   = cl[0][OUT_W] | cl[1][OUT_W] | cl[2][OUT_W]
                       | cl[3][OUT_W] | cl[4][OUT_W] | cl[5][OUT_W];
    if (z3) begin
      o_next             = '0;
      o_next.zero_length = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else if (en) begin
      v0 <= dr.valid;
      v1 <= v0;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
    if (en) begin
      z0 <= (dr.ctl.den == '0);
      q0 <= dr.ctl.n[VAL_W-1] ? -qm : qm;
      c0 <= CW'(dr.ctl.k) - CW'(dr.ctl.n[VAL_W-1] ? -qm : qm);
      n0 <= dr.ctl.n;
      for (int i = 0; i < 3; i++) begin
        t0[i] <= dr.ctl.neg[i] ? -tm[i] : tm[i];
      end

      z1 <= z0;
      q1 <= q0;
      for (int i = 0; i < 3; i++) begin
        t1[i]   <= t0[i];
        pct1[i] <= PW'(c0) * PW'(t0[i]);
        pf1[i]  <= FPW'(n0) * FPW'(t0[i]);
      end

      z2 <= z1;
      q2 <= q1;
      for (int i = 0; i < 3; i++) begin
        t2[i]  <= t1[i];
        ct2[i] <= CW'(adj2[i] >>> FRAC_BITS);
        f2[i]  <= -FW'(adjf[i] >>> FRAC_BITS);
      end

      z3 <= z2;
      q3 <= q2;
      for (int i = 0; i < 3; i++) begin
        f3[i] <= f2[i];
      end
      for (int e = 0; e < 6; e++) begin
        pb3[e] <= PW'(ct2[PI[e]]) * PW'(t2[PJ[e]]);
      end

      o4 <= o_next;
    end
  end

  assign res.valid = v4;
  assign res.data  = o4;

endmodule

// ===== rtl/truss_element_tangent_and_force.sv =====
// Top level of the 3D truss bar tangent block and internal force pipeline.
//
// One request carries both node positions, the axial stiffness k and the axial
// force n of a bar, all signed Q16.16. The response gives the symmetric 3x3
// block B = (k - n/L) t t^T + (n/L) I (the 6x6 tangent is [[B,-B],[-B,B]]) and
// the node-0 internal force -n t, as signed Q32.16 clamped to 48 bits with a
// saturated flag; coincident nodes give zero_length = 1 and all else zero.
// Throughput is one request per clock while the pipeline does not hold. From
// request to response the path runs through difference, squares and sum, the
// square root (one root bit per stage), the four-lane divider (one quotient
// bit per stage of the 49-bit dividend), products and assembly, and the
// response register. A skid register behind the pipeline lets requests
// keep flowing while one response waits; only when that register is also
// full does the pipeline hold.
module truss_element_tangent_and_force import tef_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     req_valid,
  output logic     req_ready,
  input  tef_in_t  req,
  output logic     rsp_valid,
  input  logic     rsp_ready,
  output tef_out_t rsp
);

  logic          en;
  tef_len_res_t  lr;
  tef_div_res_t  dr;
  tef_back_res_t br;
  logic          skid_valid;
  tef_out_t      skid;

  // the whole pipeline advances together unless the skid slot is taken
  assign en        = !skid_valid;
  assign req_ready = en;

  tef_len u_len (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (req_valid),
    .req      (req),
    .res      (lr)
  );

  tef_div u_div (
    .clk (clk),
    .rst (rst),
    .en  (en),
    .lr  (lr),
    .res (dr)
  );

  tef_back u_back (
    .clk (clk),
    .rst (rst),
    .en  (en),
    .dr  (dr),
    .res (br)
  );

  // response register plus skid slot
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!rsp_valid || rsp_ready) begin
      if (skid_valid) begin
        rsp_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        rsp_valid  <= br.valid;
      end
    end else if (br.valid) begin
      // the skid slot fills here, or stays full while en is low
      skid_valid <= 1'b1;
    end
    if (!rsp_valid || rsp_ready) begin
      rsp <= skid_valid ? skid : br.data;
    end else if (!skid_valid) begin
      skid <= br.data;
    end
  end

  // skid slot only fills behind a waiting response
  a_skid_behind_rsp: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> rsp_valid)
    else $error("skid slot full without a pending response");

  a_skid_fill: assert property (@(posedge clk) disable iff (rst)
    $rose(skid_valid) |-> $past(rsp_valid && !rsp_ready))
    else $error("skid slot filled while response was free");

  a_zero_len: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.zero_length) |->
      (!rsp.saturated && rsp.b_xx == '0 && rsp.b_yy == '0 && rsp.b_zz == '0 &&
       rsp.b_xy == '0 && rsp.force_x == '0 && rsp.force_z == '0))
    else $error("zero-length response carries nonzero data");

endmodule

// ===== bench/truss_element_tangent_and_force_test.sv =====
// Testbench for the truss bar tangent block and internal force pipeline.
`timescale 1ns / 1ps

module truss_element_tangent_and_force_test;
  import tef_pkg::*;

  localparam int LATENCY   = 91;
  localparam int N_RANDOM  = 680;
  localparam longint CYCLE_LIMIT = 400000;
  localparam longint Q_MAX = (64'sd1 <<< 47) - 1;
  localparam longint Q_MIN = -(64'sd1 <<< 47);

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  logic     req_valid = 1'b0;
  logic     req_ready;
  tef_in_t  req = '0;
  logic     rsp_valid;
  logic     rsp_ready = 1'b0;
  tef_out_t rsp;

  truss_element_tangent_and_force u_dut (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_ready(req_ready), .req(req),
    .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp)
  );

  always #5 clk = ~clk;

  // Idle percentages for the sender and the receiver, changed per phase.
  int unsigned send_idle = 0;
  int unsigned recv_stall = 0;

  tef_out_t expected_rsp[$];
  int unsigned errors = 0;
  int unsigned n_sent = 0;
  int unsigned n_checked = 0;
  int unsigned n_zero_len = 0;
  int unsigned n_sat = 0;
  longint cycles = 0;

  // ------------------------------------------------------------------
  // Predictor: bit-accurate tangent block and node force.
  // ------------------------------------------------------------------

  // Q.F product on magnitudes, truncated toward zero.
  function automatic longint qmul(longint a, longint b);
    logic [127:0] p;
    logic [127:0] ma;
    logic [127:0] mb;
    longint r;
    ma = (a < 0) ? 128'(-a) : 128'(a);
    mb = (b < 0) ? 128'(-b) : 128'(b);
    p = (ma * mb) >> FRAC_BITS;
    if (p > (128'd1 << 62)) p = 128'd1 << 62;
    r = longint'(p[63:0]);
    return ((a < 0) != (b < 0)) ? -r : r;
  endfunction

  function automatic longint clamp48(longint v, ref bit sat);
    if (v > Q_MAX) begin
      sat = 1'b1;
      return Q_MAX;
    end
    if (v < Q_MIN) begin
      sat = 1'b1;
      return Q_MIN;
    end
    return v;
  endfunction

  function automatic tef_out_t predict_tangent(tef_in_t a);
    longint d[3];
    longint t[3];
    longint ct[3];
    longint k;
    longint n;
    longint q;
    longint c;
    logic [127:0] sum_sq;
    logic [127:0] root;
    logic [127:0] cand;
    logic [127:0] m;
    bit sat;
    tef_out_t r;
    r = '0;
    sat = 1'b0;
    d[0] = longint'(a.end_x) - longint'(a.start_x);
    d[1] = longint'(a.end_y) - longint'(a.start_y);
    d[2] = longint'(a.end_z) - longint'(a.start_z);
    sum_sq = '0;
    for (int i = 0; i < 3; i++) begin
      m = (d[i] < 0) ? 128'(-d[i]) : 128'(d[i]);
      sum_sq += m * m;
    end
    root = '0;
    for (int b = 63; b >= 0; b--) begin
      cand = root | (128'd1 << b);
      if (cand * cand <= sum_sq) root = cand;
    end
    if (root == 0) begin
      r.zero_length = 1'b1;
      return r;
    end
    k = longint'(a.axial_stiffness);
    n = longint'(a.axial_force);
    for (int i = 0; i < 3; i++) begin
      m = (d[i] < 0) ? 128'(-d[i]) : 128'(d[i]);
      m = (m << FRAC_BITS) / root;
      t[i] = (d[i] < 0) ? -longint'(m[63:0]) : longint'(m[63:0]);
    end
    m = (n < 0) ? 128'(-n) : 128'(n);
    m = (m << FRAC_BITS) / root;
    q = (n < 0) ? -longint'(m[63:0]) : longint'(m[63:0]);
    c = k - q;
    for (int i = 0; i < 3; i++) ct[i] = qmul(c, t[i]);
    r.b_xx = OUT_W'(clamp48(qmul(ct[0], t[0]) + q, sat));
    r.b_yy = OUT_W'(clamp48(qmul(ct[1], t[1]) + q, sat));
    r.b_zz = OUT_W'(clamp48(qmul(ct[2], t[2]) + q, sat));
    r.b_xy = OUT_W'(clamp48(qmul(ct[0], t[1]), sat));
    r.b_xz = OUT_W'(clamp48(qmul(ct[0], t[2]), sat));
    r.b_yz = OUT_W'(clamp48(qmul(ct[1], t[2]), sat));
    r.force_x = OUT_W'(clamp48(-qmul(n, t[0]), sat));
    r.force_y = OUT_W'(clamp48(-qmul(n, t[1]), sat));
    r.force_z = OUT_W'(clamp48(-qmul(n, t[2]), sat));
    r.saturated = sat;
    return r;
  endfunction

  // ------------------------------------------------------------------
  // Response checking, field by field, against the oldest expectation.
  // ------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst) begin
      cycles <= cycles + 1;
      if (rsp_valid && rsp_ready) begin
        if (expected_rsp.size() == 0) begin
          $error("response with nothing expected: %p", rsp);
          errors++;
        end else begin
          tef_out_t e;
          e = expected_rsp.pop_front();
          n_checked++;
          if (e.zero_length) n_zero_len++;
          if (e.saturated) n_sat++;
          if (rsp.b_xx !== e.b_xx) begin
            $error("b_xx expected %0d got %0d", e.b_xx, rsp.b_xx); errors++;
          end
          if (rsp.b_yy !== e.b_yy) begin
            $error("b_yy expected %0d got %0d", e.b_yy, rsp.b_yy); errors++;
          end
          if (rsp.b_zz !== e.b_zz) begin
            $error("b_zz expected %0d got %0d", e.b_zz, rsp.b_zz); errors++;
          end
          if (rsp.b_xy !== e.b_xy) begin
            $error("b_xy expected %0d got %0d", e.b_xy, rsp.b_xy); errors++;
          end
          if (rsp.b_xz !== e.b_xz) begin
            $error("b_xz expected %0d got %0d", e.b_xz, rsp.b_xz); errors++;
          end
          if (rsp.b_yz !== e.b_yz) begin
            $error("b_yz expected %0d got %0d", e.b_yz, rsp.b_yz); errors++;
          end
          if (rsp.force_x !== e.force_x) begin
            $error("force_x expected %0d got %0d", e.force_x, rsp.force_x); errors++;
          end
          if (rsp.force_y !== e.force_y) begin
            $error("force_y expected %0d got %0d", e.force_y, rsp.force_y); errors++;
          end
          if (rsp.force_z !== e.force_z) begin
            $error("force_z expected %0d got %0d", e.force_z, rsp.force_z); errors++;
          end
          if (rsp.zero_length !== e.zero_length) begin
            $error("zero_length expected %0b got %0b", e.zero_length, rsp.zero_length);
            errors++;
          end
          if (rsp.saturated !== e.saturated) begin
            $error("saturated expected %0b got %0b", e.saturated, rsp.saturated); errors++;
          end
        end
      end
    end
  end

  // Receiver backpressure: one draw per cycle.
  always @(posedge clk) begin
    if (rst) rsp_ready <= 1'b0;
    else rsp_ready <= ($urandom_range(99) >= recv_stall);
  end

  // Timeout.
  always @(posedge clk) begin
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // ------------------------------------------------------------------
  // Stimulus
  // ------------------------------------------------------------------

  // Directed row: request, and whether the expected response is typed in.
  typedef struct {
    tef_in_t  a;
    bit       typed;
    tef_out_t e;
  } bar_case_t;

  bar_case_t bar_cases[$];

  // Drive one request and hold it until accepted, with random idle first.
  task automatic send_bar(tef_in_t a, bit typed, tef_out_t e);
    while ($urandom_range(99) < send_idle) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    req <= a;
    expected_rsp.push_back(typed ? e : predict_tangent(a));
    n_sent++;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_word();
    case ($urandom_range(5))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'(signed'($urandom_range(8, 0)) - 4) <<< FRAC_BITS;
      3: return 32'($urandom_range(65535)) - 32'd32768;
      default: return $urandom;
    endcase
  endfunction

  function automatic tef_in_t rand_bar();
    tef_in_t a;
    a.start_x = rand_word();
    a.start_y = rand_word();
    a.start_z = rand_word();
    a.end_x = rand_word();
    a.end_y = rand_word();
    a.end_z = rand_word();
    a.axial_stiffness = rand_word();
    a.axial_force = rand_word();
    // Sometimes make one or two components coincide, or the whole bar.
    case ($urandom_range(9))
      0: a.end_x = a.start_x;
      1: begin
        a.end_x = a.start_x; a.end_y = a.start_y; a.end_z = a.start_z;
      end
      2: begin
        a.end_y = a.start_y; a.end_z = a.start_z;
      end
      default: ;
    endcase
    return a;
  endfunction

  function automatic void add_case(tef_in_t a, bit typed, tef_out_t e);
    bar_case_t bc;
    bc.a = a;
    bc.typed = typed;
    bc.e = e;
    bar_cases.push_back(bc);
  endfunction

  function automatic tef_in_t mk_bar(logic [31:0] sx, logic [31:0] sy, logic [31:0] sz,
                                     logic [31:0] ex, logic [31:0] ey, logic [31:0] ez,
                                     logic [31:0] k, logic [31:0] n);
    tef_in_t a;
    a.start_x = sx; a.start_y = sy; a.start_z = sz;
    a.end_x = ex; a.end_y = ey; a.end_z = ez;
    a.axial_stiffness = k; a.axial_force = n;
    return a;
  endfunction

  initial begin
    tef_out_t e;
    localparam logic [31:0] ONE = 32'h0001_0000;
    localparam logic [31:0] MAXV = 32'h7fff_ffff;
    localparam logic [31:0] MINV = 32'h8000_0000;

    // All zero: coincident nodes.
    e = '0; e.zero_length = 1'b1;
    add_case(mk_bar(0, 0, 0, 0, 0, 0, 0, 0), 1'b1, e);
    // Coincident at extremes, with extreme k and n: still all zero.
    add_case(mk_bar(MAXV, MINV, MAXV, MAXV, MINV, MAXV, MAXV, MINV), 1'b1, e);
    add_case(mk_bar(MINV, MAXV, MINV, MINV, MAXV, MINV, MINV, MAXV), 1'b1, e);
    // Unit bar along x, k = 1, n = 0: B = t t^T.
    e = '0; e.b_xx = 48'sh1_0000;
    add_case(mk_bar(0, 0, 0, ONE, 0, 0, ONE, 0), 1'b1, e);
    // Unit bar along y, k = 0, n = 1: B = I - t t^T, force = -t.
    e = '0; e.b_xx = 48'sh1_0000; e.b_zz = 48'sh1_0000;
    e.force_y = -48'sh1_0000;
    add_case(mk_bar(0, 0, 0, 0, ONE, 0, 0, ONE), 1'b1, e);
    // Diagonal and negative directions, mixed signs of k and n.
    add_case(mk_bar(0, 0, 0, ONE, ONE, ONE, 32'h0003_0000, 32'hfffe_0000), 1'b0, '0);
    add_case(mk_bar(ONE, ONE, ONE, 0, 0, 0, 32'hfffd_0000, 32'h0002_0000), 1'b0, '0);
    add_case(mk_bar(0, 0, 0, 0, 0, 32'hffff_0000, MAXV, MAXV), 1'b0, '0);
    // Shortest bar (one LSB): large n/L; only the diagonal case saturates.
    add_case(mk_bar(0, 0, 0, 0, 0, 1, MAXV, MAXV), 1'b0, '0);
    add_case(mk_bar(0, 0, 0, 1, 0, 0, MINV, MINV), 1'b0, '0);
    add_case(mk_bar(0, 0, 0, 1, 1, 1, MAXV, MINV), 1'b0, '0);
    // Longest bars with coordinates at opposite extremes, then bit-pattern cases.
    add_case(mk_bar(MINV, MINV, MINV, MAXV, MAXV, MAXV, MAXV, MAXV), 1'b0, '0);
    add_case(mk_bar(MAXV, MAXV, MAXV, MINV, MINV, MINV, MINV, MINV), 1'b0, '0);
    add_case(mk_bar(MINV, 0, MAXV, MAXV, 0, MINV, ONE, ONE), 1'b0, '0);
    add_case(mk_bar(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 0, 0, 0,
                    32'h5555_5555, 32'haaaa_aaaa), 1'b0, '0);
    add_case(mk_bar(32'h5555_5555, 32'haaaa_aaaa, 32'h5555_5555,
                    32'haaaa_aaaa, 32'h5555_5555, 32'haaaa_aaaa, MINV, MAXV), 1'b0, '0);

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part, no idling.
    foreach (bar_cases[i]) send_bar(bar_cases[i].a, bar_cases[i].typed, bar_cases[i].e);

    // Random part in phases of idling.
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin send_idle = 0;  recv_stall = 0;  end
        1: begin send_idle = 68; recv_stall = 0;  end
        2: begin send_idle = 0;  recv_stall = 68; end
        3: begin send_idle = 22; recv_stall = 22; end
        default: begin send_idle = 0; recv_stall = 0; end
      endcase
      for (int j = 0; j < N_RANDOM / 5; j++) send_bar(rand_bar(), 1'b0, '0);
    end
    req_valid <= 1'b0;
    recv_stall = 0;

    while (expected_rsp.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);

    $display("sent %0d bars, checked %0d responses (%0d coincident, %0d clamped)",
             n_sent, n_checked, n_zero_len, n_sat);
    $display("idling phases: none, sender, receiver, both");
    if (errors == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

endmodule
